// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker file
// no dependencies; clock i_clk and reset i_rst_n are taken from the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, off during reset
`define AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the next cycle, off during reset
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// implication checked in the next cycle, active during reset as well
`define AST_RAW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ffba_pkg.sv =====
// constants and types of the first-fit block allocator
// no dependencies
`default_nettype none

package ffba_pkg;

    localparam int HEAP_BYTES   = 1024;
    localparam int ALIGN_BYTES  = 16;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 32;

    // header rounded up to the alignment
    localparam int HDR_PAD = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

    localparam int FIELD_W = 10;
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W  = $clog2(HEAP_BYTES);
    localparam int ADDR_W  = ((SIZE_W > FIELD_W) ? SIZE_W : FIELD_W) + 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [FIELD_W-1:0] t_field;

endpackage

`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// first-fit heap block allocator with split on allocate and merge on free
// depends on ffba_pkg
//
// Usage: pulse i_start with i_command (0 allocate, 1 free), i_request_bytes
// and i_free_offset while o_busy is low; the command is taken on that edge.
// The block table is held in registers and walked one entry per cycle by a
// small sequencer around one shared address adder and size compare.
// Allocate: the walk visits up to MAX_BLOCKS (32) table entries, and o_done
// pulses in the cycle after it with o_ok and o_payload_offset (zero on no
// fit). Free: the offset search walks up to MAX_BLOCKS entries, and a found
// block then runs a merge pass over adjacent pairs of blocks; o_done pulses
// with o_ok and a zero offset.
// A new command may be started in the cycle o_done is high.
// The result strobe cannot be held off: the receiver takes it in that cycle.
// Reset (synchronous, active low) leaves one free block covering the heap
// and the block idle; no clearing pass is needed.
`default_nettype none

module first_fit_block_allocator (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire                     i_command,
    input  wire [9:0]               i_request_bytes,
    input  wire [9:0]               i_free_offset,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [9:0]              o_payload_offset,
    output logic                    o_ok
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_FREE  = 2'd2;
    localparam logic [1:0] ST_MERGE = 2'd3;

    logic [1:0]                          r_state, n_state;
    ffba_pkg::t_addr                     r_need, n_need;
    ffba_pkg::t_field                    r_target, n_target;
    ffba_pkg::t_idx                      r_idx, n_idx;
    ffba_pkg::t_addr                     r_addr, n_addr;
    ffba_pkg::t_cnt                      r_count, n_count;
    ffba_pkg::t_size                     r_size [ffba_pkg::MAX_BLOCKS];
    ffba_pkg::t_size                     n_size [ffba_pkg::MAX_BLOCKS];
    logic [ffba_pkg::MAX_BLOCKS-1:0]     r_used, n_used;
    logic                                r_done, n_done;
    logic                                r_ok, n_ok;
    ffba_pkg::t_field                    r_off, n_off;

    ffba_pkg::t_idx  nxt_idx;
    ffba_pkg::t_size cur_size, nxt_size, merged;
    ffba_pkg::t_addr hdr_addr, step_addr, left, req_pad;
    logic            pair_end, fit, do_split;

    // shared walk arithmetic
    always_comb begin
        nxt_idx   = r_idx + ffba_pkg::t_idx'(1);
        cur_size  = r_size[r_idx];
        nxt_size  = r_size[nxt_idx];
        pair_end  = (ffba_pkg::t_cnt'(r_idx) + ffba_pkg::t_cnt'(1)) >= r_count;
        hdr_addr  = r_addr + ffba_pkg::t_addr'(ffba_pkg::HDR_PAD);
        step_addr = hdr_addr + ffba_pkg::t_addr'(cur_size);
        fit       = !r_used[r_idx] && (ffba_pkg::t_addr'(cur_size) >= r_need);
        left      = ffba_pkg::t_addr'(cur_size) - r_need;
        do_split  = (left >= ffba_pkg::t_addr'(ffba_pkg::HDR_PAD + ffba_pkg::ALIGN_BYTES))
                    && (r_count < ffba_pkg::t_cnt'(ffba_pkg::MAX_BLOCKS));
        merged    = cur_size + nxt_size + ffba_pkg::t_size'(ffba_pkg::HDR_PAD);
        req_pad   = ffba_pkg::t_addr'(((ffba_pkg::t_addr'(i_request_bytes)
                    + ffba_pkg::t_addr'(ffba_pkg::ALIGN_BYTES - 1))
                    / ffba_pkg::ALIGN_BYTES) * ffba_pkg::ALIGN_BYTES);
    end

    // sequencer and table update
    always_comb begin
        n_state  = r_state;
        n_need   = r_need;
        n_target = r_target;
        n_idx    = r_idx;
        n_addr   = r_addr;
        n_count  = r_count;
        n_size   = r_size;
        n_used   = r_used;
        n_done   = 1'b0;
        n_ok     = r_ok;
        n_off    = r_off;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_need   = req_pad;
                    n_target = i_free_offset;
                    n_idx    = '0;
                    n_addr   = '0;
                    n_state  = (i_command == ffba_pkg::CMD_FREE) ? ST_FREE : ST_ALLOC;
                end
            end
            ST_ALLOC: begin
                if (fit) begin
                    if (do_split) begin
                        for (int k = 1; k < ffba_pkg::MAX_BLOCKS; k++) begin
                            if (k > int'(r_idx) + 1) begin
                                n_size[k] = r_size[k-1];
                                n_used[k] = r_used[k-1];
                            end
                        end
                        n_size[nxt_idx] = ffba_pkg::t_size'(left
                                          - ffba_pkg::t_addr'(ffba_pkg::HDR_PAD));
                        n_used[nxt_idx] = 1'b0;
                        n_size[r_idx]   = ffba_pkg::t_size'(r_need);
                        n_count         = r_count + ffba_pkg::t_cnt'(1);
                    end
                    n_used[r_idx] = 1'b1;
                    n_done        = 1'b1;
                    n_ok          = 1'b1;
                    n_off         = hdr_addr[ffba_pkg::FIELD_W-1:0];
                    n_state       = ST_IDLE;
                end else if (pair_end) begin
                    // last entry walked without a fit
                    n_done  = 1'b1;
                    n_ok    = 1'b0;
                    n_off   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = step_addr;
                    n_idx  = nxt_idx;
                end
            end
            ST_FREE: begin
                if (hdr_addr == ffba_pkg::t_addr'(r_target)) begin
                    n_used[r_idx] = 1'b0;
                    n_idx         = '0;
                    n_state       = ST_MERGE;
                end else if (pair_end) begin
                    // last entry walked without a match
                    n_done  = 1'b1;
                    n_ok    = 1'b0;
                    n_off   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = step_addr;
                    n_idx  = nxt_idx;
                end
            end
            ST_MERGE: begin
                if (pair_end) begin
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_off   = '0;
                    n_state = ST_IDLE;
                end else if (!r_used[r_idx] && !r_used[nxt_idx]) begin
                    for (int k = 0; k < ffba_pkg::MAX_BLOCKS - 1; k++) begin
                        if (k > int'(r_idx)) begin
                            n_size[k] = r_size[k+1];
                            n_used[k] = r_used[k+1];
                        end
                    end
                    n_size[r_idx] = merged;
                    n_count       = r_count - ffba_pkg::t_cnt'(1);
                end else begin
                    n_idx = nxt_idx;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= ffba_pkg::t_cnt'(1);
            r_used  <= '0;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
            r_off   <= '0;
            for (int k = 0; k < ffba_pkg::MAX_BLOCKS; k++) begin
                r_size[k] <= (k == 0)
                             ? ffba_pkg::t_size'(ffba_pkg::HEAP_BYTES - ffba_pkg::HDR_PAD)
                             : '0;
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_used  <= n_used;
            r_done  <= n_done;
            r_ok    <= n_ok;
            r_off   <= n_off;
            r_size  <= n_size;
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        r_need   <= n_need;
        r_target <= n_target;
        r_idx    <= n_idx;
        r_addr   <= n_addr;
    end

    assign o_busy           = (r_state != ST_IDLE);
    assign o_done           = r_done;
    assign o_ok             = r_ok;
    assign o_payload_offset = r_off;

endmodule

`default_nettype wire

// ===== rtl/ffba_checker.sv =====
// port-level checks of the first-fit block allocator, bound to its top level
// depends on assert_macros.svh and ffba_pkg
`default_nettype none

`include "assert_macros.svh"

module ffba_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_start,
    input wire                          i_command,
    input wire [ffba_pkg::FIELD_W-1:0]  i_request_bytes,
    input wire [ffba_pkg::FIELD_W-1:0]  i_free_offset,
    input wire                          o_busy,
    input wire                          o_done,
    input wire [ffba_pkg::FIELD_W-1:0]  o_payload_offset,
    input wire                          o_ok
);

    logic cmd_free_q;

    // remember the kind of the last command taken
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            cmd_free_q <= i_command;
        end
    end

    // a taken command keeps the block busy
    `AST_NEXT(a_start_busy, i_start && !o_busy, o_busy)
    // a result only ends a busy period
    `AST_SAME(a_done_after_busy, o_done, $past(o_busy))
    // failures and frees carry a zero offset
    `AST_SAME(a_zero_offset, o_done && (!o_ok || cmd_free_q == ffba_pkg::CMD_FREE),
              o_payload_offset == '0)
    // reset leaves the block idle with no result
    `AST_RAW(a_reset_idle, !i_rst_n, !o_busy && !o_done)

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

`default_nettype wire

// ===== verif/ffba_checker.sv =====
`timescale 1ns / 100ps
// result scoreboard for the first-fit block allocator: watches command and result transfers
// depends on ffba_pkg; keeps its own block table and compares every result in order
module ffba_scoreboard (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_start,
    input  wire        i_busy,
    input  wire        i_command,
    input  wire [9:0]  i_request_bytes,
    input  wire [9:0]  i_free_offset,
    input  wire        i_done,
    input  wire [9:0]  i_payload_offset,
    input  wire        i_ok,
    output int         o_errors,
    output int         o_pending
);

    typedef struct packed {
        logic [9:0] offset;
        logic       ok;
    } t_grant;

    // shadow block table
    int         blk_size [ffba_pkg::MAX_BLOCKS];
    logic       blk_used [ffba_pkg::MAX_BLOCKS];
    int         blk_count;
    t_grant     grant_q[$];

    function automatic void table_reset();
        for (int i = 0; i < ffba_pkg::MAX_BLOCKS; i++) begin
            blk_size[i] = 0;
            blk_used[i] = 1'b0;
        end
        blk_size[0] = ffba_pkg::HEAP_BYTES - ffba_pkg::HDR_PAD;
        blk_count = 1;
    endfunction

    // fold every adjacent pair of free blocks
    function automatic void coalesce();
        int i;
        i = 0;
        while (i + 1 < blk_count) begin
            if (!blk_used[i] && !blk_used[i+1]) begin
                blk_size[i] += blk_size[i+1] + ffba_pkg::HDR_PAD;
                for (int k = i + 1; k + 1 < blk_count; k++) begin
                    blk_size[k] = blk_size[k+1];
                    blk_used[k] = blk_used[k+1];
                end
                blk_count--;
                blk_size[blk_count] = 0;
                blk_used[blk_count] = 1'b0;
            end else begin
                i++;
            end
        end
    endfunction

    // apply one command to the table and return the grant it yields
    function automatic t_grant apply_command(logic cmd, int req, int target);
        t_grant g;
        int     addr;
        int     need;
        int     left;
        g = '0;
        addr = 0;
        if (cmd == ffba_pkg::CMD_ALLOC) begin
            need = ((req + ffba_pkg::ALIGN_BYTES - 1) / ffba_pkg::ALIGN_BYTES)
                   * ffba_pkg::ALIGN_BYTES;
            for (int i = 0; i < blk_count; i++) begin
                if (!blk_used[i] && blk_size[i] >= need) begin
                    left = blk_size[i] - need;
                    // split only when the leftover holds a header and one unit
                    if (left >= ffba_pkg::HDR_PAD + ffba_pkg::ALIGN_BYTES
                        && blk_count < ffba_pkg::MAX_BLOCKS) begin
                        for (int k = blk_count; k > i + 1; k--) begin
                            blk_size[k] = blk_size[k-1];
                            blk_used[k] = blk_used[k-1];
                        end
                        blk_size[i+1] = left - ffba_pkg::HDR_PAD;
                        blk_used[i+1] = 1'b0;
                        blk_size[i] = need;
                        blk_count++;
                    end
                    blk_used[i] = 1'b1;
                    g.offset = 10'((addr + ffba_pkg::HDR_PAD) & 'h3FF);
                    g.ok = 1'b1;
                    return g;
                end
                addr += ffba_pkg::HDR_PAD + blk_size[i];
            end
            return g;
        end
        for (int i = 0; i < blk_count; i++) begin
            if (addr + ffba_pkg::HDR_PAD == target) begin
                blk_used[i] = 1'b0;
                coalesce();
                g.ok = 1'b1;
                return g;
            end
            addr += ffba_pkg::HDR_PAD + blk_size[i];
        end
        return g;
    endfunction

    // compare the result transfer first, then predict the command transfer
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            table_reset();
            grant_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_done) begin
                if (grant_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("%0t: result with nothing expected: offset %0d ok %0b",
                                 $realtime, i_payload_offset, i_ok);
                end else begin
                    want = grant_q.pop_front();
                    if (want.offset !== i_payload_offset || want.ok !== i_ok) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("%0t: mismatch: expected offset %0d ok %0b, got %0d ok %0b",
                                     $realtime, want.offset, want.ok, i_payload_offset, i_ok);
                    end
                end
            end
            if (i_start && !i_busy)
                grant_q.push_back(apply_command(i_command, int'(i_request_bytes),
                                                int'(i_free_offset)));
            o_pending <= grant_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// top of the allocator testbench: clock, reset, command stimulus and verdict
// depends on ffba_pkg, first_fit_block_allocator and ffba_scoreboard
module testbench;

    localparam int STALL_LIMIT = 1000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       i_command;
    logic [9:0] i_request_bytes;
    logic [9:0] i_free_offset;
    wire        o_busy;
    wire        o_done;
    wire  [9:0] o_payload_offset;
    wire        o_ok;
    int         errors;
    int         pending;
    int         quiet_cycles;
    logic       cmd_q[$];
    logic [9:0] live_q[$];

    first_fit_block_allocator dut (
        .i_clk, .i_rst_n, .i_start, .i_command, .i_request_bytes, .i_free_offset,
        .o_busy, .o_done, .o_payload_offset, .o_ok
    );

    ffba_scoreboard u_scoreboard (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_command, .i_request_bytes,
        .i_free_offset, .i_done(o_done), .i_payload_offset(o_payload_offset), .i_ok(o_ok),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // track granted offsets so frees can target live blocks
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done && cmd_q.size() != 0) begin
                if (cmd_q.pop_front() == ffba_pkg::CMD_ALLOC && o_ok)
                    live_q.push_back(o_payload_offset);
            end
            if (i_start && !o_busy)
                cmd_q.push_back(i_command);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // hold one command until its transfer, return at the next falling edge
    task automatic send_cmd(logic cmd, logic [9:0] req, logic [9:0] off);
        logic taken;
        i_start <= 1'b1;
        i_command <= cmd;
        i_request_bytes <= req;
        i_free_offset <= off;
        do begin
            taken = !o_busy;
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic maybe_idle(int pct);
        if ($urandom_range(99) < pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    task automatic free_live(logic keep);
        int idx;
        logic [9:0] off;
        idx = $urandom_range(live_q.size() - 1);
        off = live_q[idx];
        if (!keep)
            live_q.delete(idx);
        send_cmd(ffba_pkg::CMD_FREE, 10'($urandom), off);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(negedge i_clk);
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // one random command, mostly well-formed alloc/free traffic
    task automatic random_cmd();
        int pick;
        logic [9:0] req;
        pick = $urandom_range(99);
        if (pick < 48) begin
            case ($urandom_range(9))
                0, 1:    req = 10'($urandom);
                2:       req = 10'($urandom_range(0, 63) * ffba_pkg::ALIGN_BYTES);
                default: req = 10'($urandom_range(0, 120));
            endcase
            send_cmd(ffba_pkg::CMD_ALLOC, req, 10'($urandom));
        end else if (pick < 88 && live_q.size() != 0) begin
            free_live($urandom_range(19) == 0);
        end else if (pick < 94) begin
            send_cmd(ffba_pkg::CMD_FREE, 10'($urandom),
                     10'($urandom_range(0, 63) * ffba_pkg::ALIGN_BYTES));
        end else begin
            send_cmd(ffba_pkg::CMD_FREE, 10'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        int idle_pct [4] = '{0, 48, 0, 16};
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_command = ffba_pkg::CMD_ALLOC;
        i_request_bytes = '0;
        i_free_offset = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, zero request, fit edges, odd frees
        send_cmd(ffba_pkg::CMD_ALLOC, 10'd1023, 10'd0);
        send_cmd(ffba_pkg::CMD_ALLOC, 10'd0, 10'h3FF);
        send_cmd(ffba_pkg::CMD_ALLOC, 10'd1, 10'd0);
        send_cmd(ffba_pkg::CMD_ALLOC, 10'd16, 10'd0);
        send_cmd(ffba_pkg::CMD_ALLOC, 10'd17, 10'd0);
        send_cmd(ffba_pkg::CMD_FREE, 10'h3FF, 10'd5);
        send_cmd(ffba_pkg::CMD_FREE, 10'd0, 10'd16);
        send_cmd(ffba_pkg::CMD_FREE, 10'd0, 10'd16);
        send_cmd(ffba_pkg::CMD_FREE, 10'd0, 10'd1023);
        drain();
        while (live_q.size() != 0)
            free_live(1'b0);
        send_cmd(ffba_pkg::CMD_ALLOC, 10'd1008, 10'd0);
        send_cmd(ffba_pkg::CMD_ALLOC, 10'd0, 10'd0);
        drain();
        while (live_q.size() != 0)
            free_live(1'b0);
        send_cmd(ffba_pkg::CMD_ALLOC, 10'd993, 10'd0);
        drain();
        while (live_q.size() != 0)
            free_live(1'b0);
        // fill the table with zero-size blocks until splitting stops
        repeat (34) send_cmd(ffba_pkg::CMD_ALLOC, 10'd0, 10'd0);
        send_cmd(ffba_pkg::CMD_ALLOC, 10'd0, 10'd0);
        drain();
        while (live_q.size() != 0)
            free_live(1'b0);
        drain();

        // random phases with different sender idling
        foreach (idle_pct[p]) begin
            repeat (130) begin
                random_cmd();
                maybe_idle(idle_pct[p]);
            end
            drain();
        end

        i_start <= 1'b0;
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ffba_pkg.sv
rtl/first_fit_block_allocator.sv
rtl/ffba_checker.sv
verif/ffba_checker.sv
verif/testbench.sv
